// ----- rtl/abdr_pkg.sv -----
// ----------------------------------------------------------------------------
// abdr_pkg
// Types, command codes and colour helper shared by the bitmap display renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package abdr_pkg;

   // Command codes carried in the request beat
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_RENDER = 2'd1;
   localparam logic [1:0] CMD_FRAME  = 2'd2;

   // Display store layout
   localparam int unsigned BMP_BYTES  = 6144;
   localparam int unsigned ATTR_BASE  = 24 * 32 * 8;
   localparam int unsigned STORE_SIZE = 6912;

   // Pixel index of the final pixel in a cell
   localparam logic [2:0] PIX_LAST = 3'd7;

   // Attribute byte fields
   localparam int unsigned ATTR_BRIGHT = 6;
   localparam int unsigned ATTR_FLASH  = 7;

   // Flash phase bit of the frame counter (mask 0x10)
   localparam int unsigned FLASH_BIT = 4;

   // Channel levels
   localparam logic [7:0] LVL_BRIGHT = 8'hFF;
   localparam logic [7:0] LVL_NORMAL = 8'hCC;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [12:0] store_address;
      logic [7:0]  write_data;
      logic [7:0]  row;
      logic [5:0]  cell_req;
      logic [2:0]  border_colour;
   } abdr_req_type;

   typedef struct packed {
      logic [8:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [23:0] colour;
      logic        last;
   } abdr_rsp_type;

   // Per-pixel control travelling alongside the store read
   typedef struct packed {
      logic [8:0] pixel_x;
      logic [7:0] pixel_y;
      logic       border;
      logic [2:0] border_colour;
      logic [2:0] bit_sel;
      logic       flash;
      logic       last;
   } abdr_pix_type;

   // 3-bit colour (bit0 blue, bit1 red, bit2 green) to 24-bit RGB
   function automatic logic [23:0] shade(input logic [2:0] rgb3, input logic bright);
      logic [7:0] lvl;
      lvl = bright ? LVL_BRIGHT : LVL_NORMAL;
      shade = {rgb3[1] ? lvl : 8'h00, rgb3[2] ? lvl : 8'h00, rgb3[0] ? lvl : 8'h00};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/abdr_store.sv -----
// ----------------------------------------------------------------------------
// abdr_store
// Display store: bitmap and attribute memories, one write port, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module abdr_store (
   input  wire logic        clock,
   input  wire logic        wr_en,
   input  wire logic [12:0] wr_addr,
   input  wire logic [7:0]  wr_data,
   input  wire logic        rd_en,
   input  wire logic [12:0] bmp_addr,
   input  wire logic [9:0]  attr_addr,
   output      logic [7:0]  bmp_q,
   output      logic [7:0]  attr_q
);
   import abdr_pkg::*;

   logic [7:0] bmp_mem  [0:BMP_BYTES-1];
   logic [7:0] attr_mem [0:STORE_SIZE-BMP_BYTES-1];

   logic       bmp_we;
   logic       attr_we;
   logic [9:0] attr_wr_addr;
   logic [7:0] bmp_q_ff;
   logic [7:0] attr_q_ff;

   // Address decode; writes beyond the store are dropped
   assign bmp_we       = wr_en && (wr_addr < 13'(BMP_BYTES));
   assign attr_we      = wr_en && (wr_addr >= 13'(BMP_BYTES)) && (wr_addr < 13'(STORE_SIZE));
   assign attr_wr_addr = 10'(wr_addr - 13'(ATTR_BASE));

   // Bitmap memory
   always_ff @(posedge clock) begin
      if (bmp_we) begin
         bmp_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         bmp_q_ff <= bmp_mem[bmp_addr];
      end
   end

   // Attribute memory
   always_ff @(posedge clock) begin
      if (attr_we) begin
         attr_mem[attr_wr_addr] <= wr_data;
      end
      if (rd_en) begin
         attr_q_ff <= attr_mem[attr_addr];
      end
   end

   assign bmp_q  = bmp_q_ff;
   assign attr_q = attr_q_ff;

endmodule

`default_nettype wire

// ----- rtl/abdr_seq.sv -----
// ----------------------------------------------------------------------------
// abdr_seq
// Item sequencer: steps a render beat through its eight pixels, builds the
// interleaved store addresses and keeps the flash counter.
// ----------------------------------------------------------------------------
`default_nettype none

module abdr_seq #(
   parameter int unsigned BORDER_SIZE = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_accept,
   input  wire abdr_pkg::abdr_req_type req_data,
   input  wire logic                 issue_ok,
   output      logic                 hold,
   output      logic                 rd_en,
   output      logic [12:0]          bmp_addr,
   output      logic [9:0]           attr_addr,
   output      logic                 pix_issue,
   output      abdr_pkg::abdr_pix_type pix_meta
);
   import abdr_pkg::*;

   localparam int unsigned SCREEN_W = 256 + 2 * BORDER_SIZE;
   localparam int unsigned SCREEN_H = 192 + 2 * BORDER_SIZE;
   localparam int unsigned CELLS    = SCREEN_W / 8;

   localparam logic [8:0] BDR     = 9'(BORDER_SIZE);
   localparam logic [8:0] ROW_LIM = 9'(SCREEN_H);
   localparam logic [8:0] ROW_END = 9'(SCREEN_H - BORDER_SIZE);
   localparam logic [8:0] COL_END = 9'(SCREEN_W - BORDER_SIZE);
   localparam logic [6:0] CELL_LIM = 7'(CELLS);

   logic       busy_ff, busy_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] row_ff, row_in;
   logic [5:0] cell_ff, cell_in;
   logic [2:0] bcol_ff, bcol_in;
   logic [7:0] flash_ff, flash_in;

   logic       start;
   logic       issue;
   logic       last_pix;
   logic [8:0] pix_x;
   logic [8:0] row9;
   logic       border;
   logic [7:0] y;
   logic [8:0] dx;
   logic [4:0] col;

   // Render beats that fall off screen produce nothing
   assign start = req_accept && (req_data.cmd == CMD_RENDER) &&
                  ({1'b0, req_data.row} < ROW_LIM) &&
                  ({1'b0, req_data.cell_req} < CELL_LIM);

   assign issue    = busy_ff && issue_ok;
   assign last_pix = (cnt_ff == PIX_LAST);
   assign hold     = busy_ff && !(issue && last_pix);

   // Pixel position and border decision, made per pixel
   assign pix_x  = {cell_ff, 3'b000} + 9'(cnt_ff);
   assign row9   = {1'b0, row_ff};
   assign border = (row9 < BDR) || (row9 >= ROW_END) || (pix_x < BDR) || (pix_x >= COL_END);

   // Interleaved bitmap address and attribute address
   assign y         = row_ff - BDR[7:0];
   assign dx        = pix_x - BDR;
   assign col       = dx[7:3];
   assign bmp_addr  = {y[7:6], y[2:0], y[5:3], col};
   assign attr_addr = {y[7:3], col};
   assign rd_en     = issue && !border;

   assign pix_issue              = issue;
   assign pix_meta.pixel_x       = pix_x;
   assign pix_meta.pixel_y       = row_ff;
   assign pix_meta.border        = border;
   assign pix_meta.border_colour = bcol_ff;
   assign pix_meta.bit_sel       = ~dx[2:0];
   assign pix_meta.flash         = flash_ff[FLASH_BIT];
   assign pix_meta.last          = last_pix;

   // Next-state logic
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      row_in   = row_ff;
      cell_in  = cell_ff;
      bcol_in  = bcol_ff;
      flash_in = flash_ff;
      if (issue) begin
         cnt_in = cnt_ff + 3'd1;
         if (last_pix) begin
            busy_in = 1'b0;
         end
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         row_in  = req_data.row;
         cell_in = req_data.cell_req;
         bcol_in = req_data.border_colour;
      end
      if (req_accept && (req_data.cmd == CMD_FRAME)) begin
         flash_in = flash_ff + 8'd1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= 3'd0;
         flash_ff <= 8'd0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         flash_ff <= flash_in;
      end
   end

   // Captured render beat
   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      cell_ff <= cell_in;
      bcol_ff <= bcol_in;
   end

endmodule

`default_nettype wire

// ----- rtl/abdr_pix_out.sv -----
// ----------------------------------------------------------------------------
// abdr_pix_out
// Pixel colour stage: combines the store read with the pixel control and
// holds the result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module abdr_pix_out (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pix_issue,
   input  wire abdr_pkg::abdr_pix_type pix_meta,
   input  wire logic [7:0]             bmp_q,
   input  wire logic [7:0]             attr_q,
   output      logic                   issue_ok,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      abdr_pkg::abdr_rsp_type rsp_data
);
   import abdr_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   abdr_pix_type s1_ff;
   logic         out_valid_ff, out_valid_in;
   abdr_rsp_type out_ff;

   logic         out_free;
   logic         advance;
   logic [2:0]   ink;
   logic [2:0]   paper;
   logic         pix_set;
   logic [23:0]  colour;

   // Read data holds while the read stage is stalled, as no new read is issued
   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance  = s1_valid_ff && out_free;
   assign issue_ok = !s1_valid_ff || out_free;

   // Ink/paper with flash swap, then shading
   always_comb begin
      ink     = attr_q[2:0];
      paper   = attr_q[5:3];
      pix_set = bmp_q[s1_ff.bit_sel];
      if (attr_q[ATTR_FLASH] && s1_ff.flash) begin
         ink   = attr_q[5:3];
         paper = attr_q[2:0];
      end
      if (s1_ff.border) begin
         colour = shade(s1_ff.border_colour, 1'b0);
      end else begin
         colour = shade(pix_set ? ink : paper, attr_q[ATTR_BRIGHT]);
      end
   end

   // Stage occupancy
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (pix_issue) begin
         s1_valid_in = 1'b1;
      end
      if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (pix_issue) begin
         s1_ff <= pix_meta;
      end
      if (advance) begin
         out_ff.pixel_x <= s1_ff.pixel_x;
         out_ff.pixel_y <= s1_ff.pixel_y;
         out_ff.colour  <= colour;
         out_ff.last    <= s1_ff.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ----- rtl/attribute_bitmap_display_render.sv -----
// ----------------------------------------------------------------------------
// attribute_bitmap_display_render
// Character/attribute bitmap display renderer: display store writes, cell
// rendering to eight pixels, and the frame flash counter.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Beat payload      Handshake
//   req_      in          abdr_req_type     req_valid / req_stall
//   rsp_      out         abdr_rsp_type     rsp_valid / rsp_stall
//
// A render beat gives one pixel per cycle unless the result side stalls, set
// by the single read port of the display store; the next beat is taken in the
// cycle of the last pixel read. Write and end-of-frame beats raise no stall.
// Reset clears the flash counter and the pipeline; the display store is not
// cleared and holds no meaning until written.
// A stalled result holds the read stage, which in turn pauses the pixel step.
// A render pixel passes the sequencer, the read stage and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module attribute_bitmap_display_render #(
   parameter int unsigned BORDER_SIZE = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire abdr_pkg::abdr_req_type req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      abdr_pkg::abdr_rsp_type rsp_data
);
   import abdr_pkg::*;

   logic         req_accept;
   logic         wr_en;
   logic         issue_ok;
   logic         hold;
   logic         rd_en;
   logic [12:0]  bmp_addr;
   logic [9:0]   attr_addr;
   logic [7:0]   bmp_q;
   logic [7:0]   attr_q;
   logic         pix_issue;
   abdr_pix_type pix_meta;

   assign req_stall  = hold;
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && (req_data.cmd == CMD_WRITE);

   // Display store
   abdr_store u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (req_data.store_address),
      .wr_data   (req_data.write_data),
      .rd_en     (rd_en),
      .bmp_addr  (bmp_addr),
      .attr_addr (attr_addr),
      .bmp_q     (bmp_q),
      .attr_q    (attr_q)
   );

   // Sequencer and address generation
   abdr_seq #(
      .BORDER_SIZE (BORDER_SIZE)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .issue_ok   (issue_ok),
      .hold       (hold),
      .rd_en      (rd_en),
      .bmp_addr   (bmp_addr),
      .attr_addr  (attr_addr),
      .pix_issue  (pix_issue),
      .pix_meta   (pix_meta)
   );

   // Colour and output register
   abdr_pix_out u_pix_out (
      .clock     (clock),
      .reset     (reset),
      .pix_issue (pix_issue),
      .pix_meta  (pix_meta),
      .bmp_q     (bmp_q),
      .attr_q    (attr_q),
      .issue_ok  (issue_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/abdr_checker.sv -----
// ----------------------------------------------------------------------------
// abdr_checker
// Port-level checks for the bitmap display renderer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abdr_checker #(
   parameter int unsigned BORDER_SIZE = 16
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire abdr_pkg::abdr_req_type req_data,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire abdr_pkg::abdr_rsp_type rsp_data
);
   import abdr_pkg::*;

   localparam logic [8:0] ROW_LIM  = 9'(192 + 2 * BORDER_SIZE);
   localparam logic [6:0] CELL_LIM = 7'((256 + 2 * BORDER_SIZE) / 8);

   logic render_start;

   assign render_start = req_valid && !req_stall && (req_data.cmd == CMD_RENDER) &&
                         ({1'b0, req_data.row} < ROW_LIM) &&
                         ({1'b0, req_data.cell_req} < CELL_LIM);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // An on-screen render blocks the next beat while its pixels are read
   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      render_start |=> req_stall)
      else $error("request taken while a render was starting");

   // Pixels of one cell leave in order along the row
   a_pixel_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> !rsp_valid ||
         ((rsp_data.pixel_x == $past(rsp_data.pixel_x) + 9'd1) &&
          (rsp_data.pixel_y == $past(rsp_data.pixel_y))))
      else $error("pixel out of order within a cell");

   // Reset empties the pipeline and frees the request side
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind attribute_bitmap_display_render abdr_checker #(
   .BORDER_SIZE (BORDER_SIZE)
) u_abdr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap display renderer. A queue of request
// beats (store writes, cell renders, frame ends, ignored codes) is built up
// front and fed by a clocked driver with random gaps. Each accepted beat
// updates a shadow store and flash counter, and every render is expanded
// into its eight predicted pixels. A clocked monitor checks each pixel beat
// against the oldest prediction while the sink stalls at random, once for a
// long stretch so that the block backs up into its request port.
// ----------------------------------------------------------------------------
module tb_top;
   import abdr_pkg::*;

   localparam int unsigned BORDER      = 16;
   localparam int unsigned SCR_W       = 256 + 2 * BORDER;
   localparam int unsigned SCR_H       = 192 + 2 * BORDER;
   localparam int unsigned N_RANDOM    = 100;
   localparam int unsigned MAX_WAIT    = 16;
   localparam int unsigned DRAIN       = 16;
   localparam int unsigned HOLD_AT     = 120;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned REPORT_CAP  = 40;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [1:0]  CMD_SPARE   = 2'd3;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   abdr_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   abdr_rsp_type rsp_data;

   // Stimulus side: pending beats and which store bytes they have written
   abdr_req_type beat_backlog[$];
   bit           gen_written [STORE_SIZE];

   // Shadow state and predicted pixel stream
   logic [7:0]   shadow_store [STORE_SIZE];
   logic [7:0]   shadow_flash = 8'd0;
   abdr_rsp_type pixel_queue[$];
   abdr_rsp_type want_px;

   int unsigned  failures    = 0;
   int unsigned  pixels_seen = 0;
   int unsigned  cmd_seen [4];
   int unsigned  cycle_count = 0;
   int unsigned  send_wait   = 0;
   bit           send_calm   = 1'b0;
   int unsigned  stall_left  = 0;
   int unsigned  hold_left   = 0;
   bit           hold_done   = 1'b0;
   bit           sink_calm   = 1'b0;
   int unsigned  sink_draw;

   attribute_bitmap_display_render #(
      .BORDER_SIZE (BORDER)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock and a single reset pulse
   always #4 clock = ~clock;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Screen position to store addresses; 0 means a border pixel
   function automatic bit pixel_source(input int unsigned x, input int unsigned row_no,
                                       output int unsigned bmp_a, output int unsigned attr_a);
      int unsigned y;
      int unsigned col;
      bmp_a  = 0;
      attr_a = 0;
      if (row_no < BORDER || row_no >= SCR_H - BORDER || x < BORDER || x >= SCR_W - BORDER)
         return 1'b0;
      y      = row_no - BORDER;
      col    = (x - BORDER) / 8;
      bmp_a  = (y / 64) * 2048 + (y % 8) * 256 + ((y % 64) / 8) * 32 + col;
      attr_a = ATTR_BASE + (y / 8) * 32 + col;
      return 1'b1;
   endfunction

   // 3-bit colour to 24-bit RGB, one channel at a time
   function automatic logic [23:0] rgb_of(input logic [2:0] c3, input bit bright);
      logic [7:0]  lvl;
      logic [23:0] rgb;
      lvl = bright ? LVL_BRIGHT : LVL_NORMAL;
      rgb = '0;
      if (c3[0]) rgb[7:0]   = lvl;
      if (c3[1]) rgb[23:16] = lvl;
      if (c3[2]) rgb[15:8]  = lvl;
      return rgb;
   endfunction

   // Apply one accepted beat to the shadow state; renders add eight pixels
   function automatic void predict_beat(input abdr_req_type b);
      int unsigned  x;
      int unsigned  bmp_a;
      int unsigned  attr_a;
      logic [7:0]   bmp_byte;
      logic [7:0]   attr;
      logic [2:0]   ink;
      logic [2:0]   paper;
      abdr_rsp_type px;
      case (b.cmd)
         CMD_WRITE: begin
            if (b.store_address < STORE_SIZE)
               shadow_store[b.store_address] = b.write_data;
         end
         CMD_FRAME: begin
            shadow_flash = shadow_flash + 8'd1;
         end
         CMD_RENDER: begin
            if (b.row < SCR_H && b.cell_req < SCR_W / 8) begin
               for (int i = 0; i < 8; i++) begin
                  x = b.cell_req * 8 + i;
                  px.pixel_x = x[8:0];
                  px.pixel_y = b.row;
                  px.last    = (i == PIX_LAST);
                  if (!pixel_source(x, b.row, bmp_a, attr_a)) begin
                     px.colour = rgb_of(b.border_colour, 1'b0);
                  end else begin
                     bmp_byte = shadow_store[bmp_a];
                     attr     = shadow_store[attr_a];
                     ink      = attr[2:0];
                     paper    = attr[5:3];
                     // flash phase swaps ink and paper
                     if (attr[ATTR_FLASH] && shadow_flash[FLASH_BIT]) begin
                        ink   = attr[5:3];
                        paper = attr[2:0];
                     end
                     px.colour = rgb_of(bmp_byte[7 - (x - BORDER) % 8] ? ink : paper,
                                        attr[ATTR_BRIGHT]);
                  end
                  pixel_queue.push_back(px);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Stimulus builders
   function automatic abdr_req_type random_beat();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[$bits(abdr_req_type)-1:0];
   endfunction

   function automatic void queue_beat(input abdr_req_type b);
      if (b.cmd == CMD_WRITE && b.store_address < STORE_SIZE)
         gen_written[b.store_address] = 1'b1;
      beat_backlog.push_back(b);
   endfunction

   function automatic void queue_write(input int unsigned addr, input logic [7:0] data);
      abdr_req_type b;
      b               = random_beat();
      b.cmd           = CMD_WRITE;
      b.store_address = addr[12:0];
      b.write_data    = data;
      queue_beat(b);
   endfunction

   function automatic void queue_plain(input logic [1:0] code);
      abdr_req_type b;
      b     = random_beat();
      b.cmd = code;
      queue_beat(b);
   endfunction

   // Render beat, preceded by writes of any bytes it reads that are unwritten
   // (or all of them when refresh is set)
   function automatic void queue_render(input int unsigned row_no, input int unsigned cell_no,
                                        input logic [2:0] border_c, input bit refresh);
      abdr_req_type b;
      int unsigned  bmp_a;
      int unsigned  attr_a;
      int unsigned  last_bmp;
      int unsigned  last_attr;
      last_bmp  = STORE_SIZE;
      last_attr = STORE_SIZE;
      for (int i = 0; i < 8; i++) begin
         if (pixel_source(cell_no * 8 + i, row_no, bmp_a, attr_a)) begin
            if (!gen_written[bmp_a] || (refresh && bmp_a != last_bmp))
               queue_write(bmp_a, 8'($urandom_range(0, 255)));
            if (!gen_written[attr_a] || (refresh && attr_a != last_attr))
               queue_write(attr_a, 8'($urandom_range(0, 255)));
            last_bmp  = bmp_a;
            last_attr = attr_a;
         end
      end
      b               = random_beat();
      b.cmd           = CMD_RENDER;
      b.row           = row_no[7:0];
      b.cell_req      = cell_no[5:0];
      b.border_colour = border_c;
      queue_beat(b);
   endfunction

   function automatic int unsigned draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // Driver: present backlog beats with random gaps, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_beat(req_data);
            cmd_seen[req_data.cmd]++;
         end
         if (!req_valid || !req_stall) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (beat_backlog.size() != 0) begin
               req_data  <= beat_backlog.pop_front();
               req_valid <= 1'b1;
               send_wait <= draw_wait(send_calm);
               if ($urandom_range(0, 31) == 0)
                  send_calm <= !send_calm;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Sink: random stall per pixel beat, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && pixels_seen >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         sink_draw = draw_wait(sink_calm);
         stall_left <= sink_draw;
         rsp_stall  <= (sink_draw != 0);
         if ($urandom_range(0, 31) == 0)
            sink_calm <= !sink_calm;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void flag_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endfunction

   // Monitor: each pixel beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         pixels_seen <= pixels_seen + 1;
         if (pixel_queue.size() == 0) begin
            failures++;
            if (failures <= REPORT_CAP)
               $display("%0t: pixel beat with none pending, expected nothing, got %h",
                        $time, rsp_data);
         end else begin
            want_px = pixel_queue.pop_front();
            flag_field("pixel_x", want_px.pixel_x, rsp_data.pixel_x);
            flag_field("pixel_y", want_px.pixel_y, rsp_data.pixel_y);
            flag_field("colour",  want_px.colour,  rsp_data.colour);
            flag_field("last",    want_px.last,    rsp_data.last);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: no finish after %0d cycles, %0d pixels still pending",
                  $time, CYCLE_LIMIT, pixel_queue.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int unsigned counted;
      int unsigned pick;
      counted = 0;

      // border corners and edges, border colour extremes
      queue_render(0, 0, 3'd7, 1'b0);
      queue_render(SCR_H - 1, SCR_W / 8 - 1, 3'd0, 1'b0);
      queue_render(BORDER - 1, BORDER / 8, 3'd5, 1'b0);
      queue_render(BORDER, BORDER / 8 - 1, 3'd2, 1'b0);
      // first display cell: solid ink, bright white on black
      queue_write(0, 8'hFF);
      queue_write(ATTR_BASE, 8'h47);
      queue_render(BORDER, BORDER / 8, 3'd1, 1'b0);
      // last display cell, flashing attribute, counter phase clear
      queue_write(BMP_BYTES - 1, 8'hA5);
      queue_write(STORE_SIZE - 1, 8'hBA);
      queue_render(SCR_H - BORDER - 1, (SCR_W - BORDER) / 8 - 1, 3'd4, 1'b0);
      // writes beyond the store are dropped
      queue_write(STORE_SIZE, 8'h00);
      queue_write(8191, 8'hFF);
      // off-screen renders and the spare code give nothing
      queue_render(SCR_H, 0, 3'd3, 1'b0);
      queue_render(255, 63, 3'd6, 1'b0);
      queue_render(0, SCR_W / 8, 3'd7, 1'b0);
      queue_plain(CMD_SPARE);
      queue_plain(CMD_FRAME);
      queue_render(SCR_H - BORDER - 1, (SCR_W - BORDER) / 8 - 1, 3'd4, 1'b0);

      // random mix, mostly write-then-render sequences into the display area
      while (counted < N_RANDOM) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 9) < 7)
               queue_render($urandom_range(BORDER, SCR_H - BORDER - 1),
                            $urandom_range(BORDER / 8, (SCR_W - BORDER) / 8 - 1),
                            3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            else
               queue_render($urandom_range(0, SCR_H - 1), $urandom_range(0, SCR_W / 8 - 1),
                            3'($urandom_range(0, 7)), 1'b0);
            counted++;
         end else if (pick < 72) begin
            queue_write($urandom_range(0, STORE_SIZE - 1), 8'($urandom_range(0, 255)));
            counted++;
         end else if (pick < 85) begin
            queue_plain(CMD_FRAME);
            counted++;
         end else if (pick < 90) begin
            queue_write($urandom_range(STORE_SIZE, 8191), 8'($urandom_range(0, 255)));
         end else if (pick < 95) begin
            if ($urandom_range(0, 1))
               queue_render($urandom_range(SCR_H, 255), $urandom_range(0, 63),
                            3'($urandom_range(0, 7)), 1'b0);
            else
               queue_render($urandom_range(0, 255), $urandom_range(SCR_W / 8, 63),
                            3'($urandom_range(0, 7)), 1'b0);
         end else begin
            queue_plain(CMD_SPARE);
         end
      end

      // drain: everything sent, every pixel back, then a quiet drain period
      while (beat_backlog.size() != 0 || req_valid || pixel_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (pixel_queue.size() != 0) begin
         failures++;
         $display("%0t: %0d predicted pixels never arrived", $time, pixel_queue.size());
      end
      $display("Sent %0d beats: %0d writes, %0d renders, %0d frame ends, %0d spare codes.",
               cmd_seen[CMD_WRITE] + cmd_seen[CMD_RENDER] + cmd_seen[CMD_FRAME]
               + cmd_seen[CMD_SPARE], cmd_seen[CMD_WRITE], cmd_seen[CMD_RENDER],
               cmd_seen[CMD_FRAME], cmd_seen[CMD_SPARE]);
      $display("Checked %0d pixel beats, flash counter ended at %0d, %0d problems.",
               pixels_seen, shadow_flash, failures);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
